>>> design/ctt_pkg.sv
package ctt_pkg;

  localparam int TAG_W  = 6;
  localparam int DESC_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [0:0] {
    OP_POST = 1'b0,
    OP_MSG  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    RES_POSTED      = 3'd0,
    RES_NOT_READY   = 3'd1,
    RES_INVALID     = 3'd2,
    RES_NO_TAG      = 3'd3,
    RES_PUSH_FAILED = 3'd4,
    RES_DONE        = 3'd5,
    RES_UNKNOWN     = 3'd6,
    RES_EVENT       = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    TS_FREE      = 2'd0,
    TS_PENDING   = 2'd1,
    TS_USED      = 2'd2,
    TS_CANCELLED = 2'd3
  } tag_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_READY      = 3'd0,
    CFG_QUEUE_B    = 3'd1,
    CFG_QUEUE_NUM  = 3'd2,
    CFG_HEADER_B   = 3'd3,
    CFG_UNIT_LIM   = 3'd4,
    CFG_EVENT_CODE = 3'd5,
    CFG_FLAG_MASK  = 3'd6
  } cfg_idx_t;

  // table update, applied at the edge the request leaves the input register
  typedef struct packed {
    logic              alloc;
    logic              pushed;
    logic [DESC_W-1:0] desc;
    logic              release_tag;
  } tbl_cmd_t;

  // lookup results for the request in the input register
  typedef struct packed {
    logic              free_found;
    logic [TAG_W-1:0]  free_tag;
    logic              hit;
    logic [DESC_W-1:0] desc;
  } tbl_look_t;

endpackage

>>> design/ctt_tag_table.sv
module ctt_tag_table #(
  parameter int TAG_COUNT = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  logic [ctt_pkg::TAG_W-1:0] load_tag,
  input  logic [ctt_pkg::TAG_W-1:0] cur_tag,
  input  ctt_pkg::tbl_cmd_t       cmd,
  output ctt_pkg::tbl_look_t      look
);
  import ctt_pkg::*;

  localparam int SPAN  = (TAG_COUNT < 64) ? TAG_COUNT : 64;
  localparam int IDX_W = $clog2(SPAN);

  tag_state_t        tag_state [SPAN];
  logic [DESC_W-1:0] desc_mem [SPAN];
  logic [DESC_W-1:0] rd_q;
  logic              byp;
  logic [DESC_W-1:0] byp_data;

  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [IDX_W-1:0]  load_idx;
  logic [IDX_W-1:0]  cur_idx;
  logic              cur_in_pool;
  tag_state_t        cur_state;

  assign load_idx    = load_tag[IDX_W-1:0];
  assign cur_idx     = cur_tag[IDX_W-1:0];
  assign cur_in_pool = {1'b0, cur_tag} < 7'(SPAN);
  assign cur_state   = tag_state[cur_idx];

  // lowest free tag
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SPAN - 1; i >= 0; i--) begin
      if (tag_state[i] == TS_FREE) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SPAN; i++) begin
        tag_state[i] <= TS_FREE;
      end
    end else if (cmd.alloc) begin
      tag_state[free_idx] <= cmd.pushed ? TS_USED : TS_PENDING;
    end else if (cmd.release_tag) begin
      tag_state[cur_idx] <= TS_FREE;
    end
  end

  // descriptor store; a read is only used on a hit, after a post wrote the entry
  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      desc_mem[free_idx] <= cmd.desc;
    end
    if (load) begin
      rd_q <= desc_mem[load_idx];
    end
  end

  // forward a write that lands on the same edge as the read
  always_ff @(posedge clk) begin
    if (load) begin
      byp      <= cmd.alloc && (free_idx == load_idx);
      byp_data <= cmd.desc;
    end
  end

  always_comb begin
    look.free_found = free_found;
    look.free_tag   = TAG_W'(free_idx);
    look.hit        = cur_in_pool &&
                      (cur_state == TS_USED || cur_state == TS_CANCELLED);
    look.desc       = byp ? byp_data : rd_q;
  end

  a_no_alloc_release: assert property (@(posedge clk) disable iff (rst)
    !(cmd.alloc && cmd.release_tag))
    else $error("alloc and release in one cycle");

  a_alloc_needs_free: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |-> free_found)
    else $error("alloc with no free tag");

  a_alloc_takes: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |=> tag_state[$past(free_idx)] != TS_FREE)
    else $error("allocated tag still free");

  a_release_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.release_tag |-> look.hit)
    else $error("release of a tag not in use");

endmodule

>>> design/command_sequence_tag_tracker_top.sv
// Flow: a request accepted into the input register moves on, with out_valid, into
//   the result register when that register is empty or its result is taken.
// Throughput: one request per cycle unless out_stall holds; set by the single-entry
//   tag table update and the lowest-free-tag priority encoder between the registers.
// Reset (rst, synchronous, high): all tags free, next descriptor 0, config
//   registers to defaults, both registers empty. No clearing pass is needed.
module command_sequence_tag_tracker_top #(
  parameter int TAG_COUNT = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // config port
  input  logic                              cfg_write,
  input  logic [ctt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ctt_pkg::CFG_DATA_W-1:0]    cfg_data,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              op,
  input  logic [2:0]                        queue_number,
  input  logic [7:0]                        command_size,
  input  logic [7:0]                        unit_id,
  input  logic                              push_ok,
  input  logic [ctt_pkg::TAG_W-1:0]         message_tag,
  input  logic [7:0]                        control_flags,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        status,
  output logic [ctt_pkg::TAG_W-1:0]         tag,
  output logic [ctt_pkg::DESC_W-1:0]        descriptor
);
  import ctt_pkg::*;

  // config registers
  logic        ready_cfg;
  logic [15:0] queue_bytes;
  logic [2:0]  command_queue_number;
  logic [7:0]  header_bytes;
  logic [7:0]  unit_limit;
  logic [7:0]  event_code;
  logic [7:0]  engine_flag_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_cfg            <= 1'b0;
      queue_bytes          <= 16'd1024;
      command_queue_number <= 3'd0;
      header_bytes         <= 8'd4;
      unit_limit           <= 8'd16;
      event_code           <= 8'd0;
      engine_flag_mask     <= 8'd0;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_READY:      ready_cfg            <= cfg_data[0];
        CFG_QUEUE_B:    queue_bytes          <= cfg_data;
        CFG_QUEUE_NUM:  command_queue_number <= cfg_data[2:0];
        CFG_HEADER_B:   header_bytes         <= cfg_data[7:0];
        CFG_UNIT_LIM:   unit_limit           <= cfg_data[7:0];
        CFG_EVENT_CODE: event_code           <= cfg_data[7:0];
        CFG_FLAG_MASK:  engine_flag_mask     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input register
  logic        s1_valid;
  op_t         s1_op;
  logic [2:0]  s1_qn;
  logic [7:0]  s1_size;
  logic [7:0]  s1_unit;
  logic        s1_push;
  logic [TAG_W-1:0] s1_tag;
  logic [7:0]  s1_flags;

  logic advance;   // result register can take a new result
  logic fire;      // request in input register is processed this cycle
  logic load;      // new request accepted

  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_op    <= op_t'(op);
      s1_qn    <= queue_number;
      s1_size  <= command_size;
      s1_unit  <= unit_id;
      s1_push  <= push_ok;
      s1_tag   <= message_tag;
      s1_flags <= control_flags;
    end
  end

  // tag table
  tbl_cmd_t  cmd;
  tbl_look_t look;

  ctt_tag_table #(
    .TAG_COUNT (TAG_COUNT)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .load_tag (message_tag),
    .cur_tag  (s1_tag),
    .cmd      (cmd),
    .look     (look)
  );

  // decision logic
  logic [DESC_W-1:0] next_descriptor;
  logic [DESC_W-1:0] next_descriptor_next;
  logic [7:0]        masked_flags;
  logic              post_bad;
  status_t           res_status;
  logic [TAG_W-1:0]  res_tag;
  logic [DESC_W-1:0] res_desc;
  logic              do_alloc;
  logic              do_release;

  assign masked_flags = s1_flags & ~engine_flag_mask;
  assign post_bad = (s1_qn != command_queue_number) ||
                    (s1_size < header_bytes) ||
                    ({8'h00, s1_size} > {1'b0, queue_bytes[15:1]}) ||
                    (s1_unit >= unit_limit);

  always_comb begin
    res_status = RES_UNKNOWN;
    res_tag    = '0;
    res_desc   = '0;
    do_alloc   = 1'b0;
    do_release = 1'b0;
    case (s1_op)
      OP_POST: begin
        if (!ready_cfg) begin
          res_status = RES_NOT_READY;
        end else if (post_bad) begin
          res_status = RES_INVALID;
        end else if (!look.free_found) begin
          res_status = RES_NO_TAG;
        end else begin
          res_status = s1_push ? RES_POSTED : RES_PUSH_FAILED;
          res_tag    = look.free_tag;
          res_desc   = next_descriptor;
          do_alloc   = 1'b1;
        end
      end
      OP_MSG: begin
        res_tag = s1_tag;
        if (masked_flags == event_code) begin
          res_status = RES_EVENT;
        end else if (look.hit) begin
          res_status = RES_DONE;
          res_desc   = look.desc;
          do_release = 1'b1;
        end else begin
          res_status = RES_UNKNOWN;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd.alloc       = fire && do_alloc;
    cmd.pushed      = s1_push;
    cmd.desc        = next_descriptor;
    cmd.release_tag = fire && do_release;
  end

  assign next_descriptor_next = next_descriptor + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      next_descriptor <= '0;
    end else if (cmd.alloc) begin
      next_descriptor <= next_descriptor_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status     <= res_status;
      tag        <= res_tag;
      descriptor <= res_desc;
    end
  end

  a_desc_step: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |=> next_descriptor == $past(next_descriptor) + 32'd1)
    else $error("descriptor did not advance on post");

  a_desc_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.alloc |=> next_descriptor == $past(next_descriptor))
    else $error("descriptor moved without a post");

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ctt_pkg::*;

  localparam int          TAG_COUNT   = 64;
  // the free-tag search never looks past 64 tags, whatever the pool size
  localparam int          TAG_SPAN    = (TAG_COUNT < 64) ? TAG_COUNT : 64;
  localparam logic [31:0] INVALID_DESC = 32'hFFFF_FFFF;
  localparam int          SETTLE      = 4;    // cycles after the last result before a write
  localparam int          HOLD_CYCLES = 120;  // long sink back-pressure stretch
  localparam int          LEAK_CAP    = 40;   // pending tags are never freed, so ration them

  // one request as driven on the request channel
  typedef struct packed {
    op_t         op;
    logic [2:0]  qn;
    logic [7:0]  size;
    logic [7:0]  unit;
    logic        push;
    logic [5:0]  mtag;
    logic [7:0]  flags;
  } request_t;

  // one result as seen on the result channel
  typedef struct packed {
    status_t     status;
    logic [5:0]  tag;
    logic [31:0] desc;
  } result_t;

  // directed row: optional register write (block idle), then one request;
  // typed rows carry their result, the rest go through the tag tracker model
  typedef struct packed {
    logic        wr;
    cfg_idx_t    reg_idx;
    logic [15:0] reg_val;
    request_t    req;
    logic        typed;
    result_t     res;
  } vector_t;

  localparam int N_DIRECTED = 24;
  localparam vector_t DIRECTED [N_DIRECTED] = '{
    // not ready: posts refused, messages still handled
    '{1'b0, CFG_READY, 16'd0, '{OP_POST, 3'd0, 8'd4, 8'd0, 1'b1, 6'd0, 8'h00},
      1'b1, '{RES_NOT_READY, 6'd0, 32'd0}},
    '{1'b0, CFG_READY, 16'd0, '{OP_MSG, 3'd0, 8'd0, 8'd0, 1'b0, 6'd63, 8'h00},
      1'b1, '{RES_EVENT, 6'd63, 32'd0}},
    '{1'b0, CFG_READY, 16'd0, '{OP_MSG, 3'd0, 8'd0, 8'd0, 1'b0, 6'd5, 8'h01},
      1'b1, '{RES_UNKNOWN, 6'd5, 32'd0}},
    // first post gets tag 0 / descriptor 0, then a failed push leaves tag 1 pending
    '{1'b1, CFG_READY, 16'd1, '{OP_POST, 3'd0, 8'd4, 8'd0, 1'b1, 6'd0, 8'h00},
      1'b1, '{RES_POSTED, 6'd0, 32'd0}},
    '{1'b0, CFG_READY, 16'd0, '{OP_POST, 3'd0, 8'd255, 8'd15, 1'b0, 6'd0, 8'h00},
      1'b1, '{RES_PUSH_FAILED, 6'd1, 32'd1}},
    // response to a pending tag is unknown and leaves it taken
    '{1'b0, CFG_READY, 16'd0, '{OP_MSG, 3'd0, 8'd0, 8'd0, 1'b0, 6'd1, 8'hFF},
      1'b1, '{RES_UNKNOWN, 6'd1, 32'd0}},
    '{1'b0, CFG_READY, 16'd0, '{OP_MSG, 3'd0, 8'd0, 8'd0, 1'b0, 6'd0, 8'h80},
      1'b1, '{RES_DONE, 6'd0, 32'd0}},
    // invalid: queue, size under header, unit at and above limit
    '{1'b0, CFG_READY, 16'd0, '{OP_POST, 3'd7, 8'd4, 8'd0, 1'b1, 6'd0, 8'h00},
      1'b1, '{RES_INVALID, 6'd0, 32'd0}},
    '{1'b0, CFG_READY, 16'd0, '{OP_POST, 3'd0, 8'd3, 8'd0, 1'b1, 6'd0, 8'h00},
      1'b1, '{RES_INVALID, 6'd0, 32'd0}},
    '{1'b0, CFG_READY, 16'd0, '{OP_POST, 3'd0, 8'd4, 8'd16, 1'b1, 6'd0, 8'h00},
      1'b1, '{RES_INVALID, 6'd0, 32'd0}},
    '{1'b0, CFG_READY, 16'd0, '{OP_POST, 3'd0, 8'd255, 8'd255, 1'b1, 6'd0, 8'h00},
      1'b1, '{RES_INVALID, 6'd0, 32'd0}},
    // freed tag 0 is the lowest free again, descriptor keeps counting
    '{1'b0, CFG_READY, 16'd0, '{OP_POST, 3'd0, 8'd128, 8'd3, 1'b1, 6'd0, 8'h00},
      1'b1, '{RES_POSTED, 6'd0, 32'd2}},
    // one-byte queue: any size above zero is too big
    '{1'b1, CFG_QUEUE_B, 16'd1, '{OP_POST, 3'd0, 8'd4, 8'd0, 1'b1, 6'd0, 8'h00},
      1'b1, '{RES_INVALID, 6'd0, 32'd0}},
    '{1'b1, CFG_HEADER_B, 16'd0, '{OP_POST, 3'd0, 8'd0, 8'd0, 1'b1, 6'd0, 8'h00},
      1'b0, '0},
    '{1'b1, CFG_QUEUE_B, 16'hFFFF, '{OP_POST, 3'd0, 8'd255, 8'd0, 1'b1, 6'd0, 8'h00},
      1'b0, '0},
    '{1'b1, CFG_QUEUE_NUM, 16'd7, '{OP_POST, 3'd7, 8'd100, 8'd0, 1'b1, 6'd0, 8'h00},
      1'b0, '0},
    '{1'b1, CFG_UNIT_LIM, 16'd255, '{OP_POST, 3'd7, 8'd5, 8'd254, 1'b1, 6'd0, 8'h00},
      1'b0, '0},
    '{1'b0, CFG_READY, 16'd0, '{OP_POST, 3'd7, 8'd5, 8'd255, 1'b1, 6'd0, 8'h00},
      1'b1, '{RES_INVALID, 6'd0, 32'd0}},
    '{1'b1, CFG_UNIT_LIM, 16'd0, '{OP_POST, 3'd7, 8'd5, 8'd0, 1'b1, 6'd0, 8'h00},
      1'b1, '{RES_INVALID, 6'd0, 32'd0}},
    // event code and engine flag masking
    '{1'b1, CFG_EVENT_CODE, 16'hFF, '{OP_MSG, 3'd0, 8'd0, 8'd0, 1'b0, 6'd7, 8'hFF},
      1'b1, '{RES_EVENT, 6'd7, 32'd0}},
    '{1'b1, CFG_FLAG_MASK, 16'hF0, '{OP_MSG, 3'd0, 8'd0, 8'd0, 1'b0, 6'd2, 8'hFA},
      1'b0, '0},
    '{1'b1, CFG_EVENT_CODE, 16'h0F, '{OP_MSG, 3'd0, 8'd0, 8'd0, 1'b0, 6'd0, 8'hFF},
      1'b1, '{RES_EVENT, 6'd0, 32'd0}},
    '{1'b0, CFG_READY, 16'd0, '{OP_MSG, 3'd0, 8'd0, 8'd0, 1'b0, 6'd3, 8'h10},
      1'b0, '0},
    '{1'b1, CFG_READY, 16'd0, '{OP_POST, 3'd7, 8'd5, 8'd0, 1'b1, 6'd0, 8'h00},
      1'b1, '{RES_NOT_READY, 6'd0, 32'd0}}
  };

  // clock, reset, and every block input at a known value from time zero
  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_write     = 1'b0;
  logic [2:0]  cfg_index     = '0;
  logic [15:0] cfg_data      = '0;
  logic        in_valid      = 1'b0;
  logic        op            = 1'b0;
  logic [2:0]  queue_number  = '0;
  logic [7:0]  command_size  = '0;
  logic [7:0]  unit_id       = '0;
  logic        push_ok       = 1'b0;
  logic [5:0]  message_tag   = '0;
  logic [7:0]  control_flags = '0;
  logic        out_stall     = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  status;
  logic [5:0]  tag;
  logic [31:0] descriptor;

  // tag tracker model state and its copy of the registers
  bit          tag_taken [TAG_COUNT];
  tag_state_t  tag_phase [TAG_COUNT];
  logic [31:0] tag_desc  [TAG_COUNT];
  logic [31:0] desc_next;
  logic        ready_m;
  logic [15:0] qbytes_m;
  logic [2:0]  qnum_m;
  logic [7:0]  hdr_m;
  logic [7:0]  unit_lim_m;
  logic [7:0]  evt_m;
  logic [7:0]  mask_m;

  result_t     results_due [$];  // expected results, oldest first
  int unsigned mismatches = 0;
  bit          hold_request = 1'b0;  // asks the sink for one long stall

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  command_sequence_tag_tracker_top #(
    .TAG_COUNT(TAG_COUNT)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .queue_number (queue_number),
    .command_size (command_size),
    .unit_id      (unit_id),
    .push_ok      (push_ok),
    .message_tag  (message_tag),
    .control_flags(control_flags),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .tag          (tag),
    .descriptor   (descriptor)
  );

  function automatic void tracker_reset();
    for (int i = 0; i < TAG_COUNT; i++) begin
      tag_taken[i] = 1'b0;
      tag_phase[i] = TS_FREE;
      tag_desc[i]  = INVALID_DESC;
    end
    desc_next  = '0;
    ready_m    = 1'b0;
    qbytes_m   = 16'd1024;
    qnum_m     = 3'd0;
    hdr_m      = 8'd4;
    unit_lim_m = 8'd16;
    evt_m      = 8'd0;
    mask_m     = 8'd0;
  endfunction

  function automatic void mirror_reg(cfg_idx_t idx, logic [15:0] val);
    case (idx)
      CFG_READY:      ready_m    = val[0];
      CFG_QUEUE_B:    qbytes_m   = val;
      CFG_QUEUE_NUM:  qnum_m     = val[2:0];
      CFG_HEADER_B:   hdr_m      = val[7:0];
      CFG_UNIT_LIM:   unit_lim_m = val[7:0];
      CFG_EVENT_CODE: evt_m      = val[7:0];
      CFG_FLAG_MASK:  mask_m     = val[7:0];
      default: ;
    endcase
  endfunction

  // Apply one accepted request to the tag table, return the result it gives.
  function automatic result_t track_request(request_t r);
    result_t    res;
    int         t;
    logic [7:0] masked;
    res.status = RES_NOT_READY;
    res.tag    = '0;
    res.desc   = '0;
    if (r.op == OP_POST) begin
      if (!ready_m) begin
        res.status = RES_NOT_READY;
      end else if (r.qn != qnum_m || r.size < hdr_m || {8'd0, r.size} > (qbytes_m >> 1) ||
                   r.unit >= unit_lim_m) begin
        res.status = RES_INVALID;
      end else begin
        t = 0;
        while (t < TAG_SPAN && tag_taken[t]) t++;
        if (t >= TAG_SPAN) begin
          res.status = RES_NO_TAG;
        end else begin
          tag_taken[t] = 1'b1;
          tag_desc[t]  = desc_next;
          desc_next    = desc_next + 32'd1;
          tag_phase[t] = r.push ? TS_USED : TS_PENDING;
          res.status   = r.push ? RES_POSTED : RES_PUSH_FAILED;
          res.tag      = t[5:0];
          res.desc     = tag_desc[t];
        end
      end
    end else begin
      masked  = r.flags & ~mask_m;
      res.tag = r.mtag;
      if (masked == evt_m) begin
        res.status = RES_EVENT;
      end else if (r.mtag >= TAG_COUNT ||
                   (tag_phase[r.mtag] != TS_USED && tag_phase[r.mtag] != TS_CANCELLED)) begin
        res.status = RES_UNKNOWN;
      end else begin
        res.status          = RES_DONE;
        res.desc            = tag_desc[r.mtag];
        tag_phase[r.mtag]   = TS_FREE;
        tag_desc[r.mtag]    = INVALID_DESC;
        tag_taken[r.mtag]   = 1'b0;
      end
    end
    return res;
  endfunction

  // mostly zero, sometimes a few cycles, rarely a long gap
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Well-formed posts pass the queue, size and unit checks where the registers allow;
  // well-formed messages answer a used tag if one is outstanding. Noise is random in every field.
  function automatic request_t make_request(int unsigned post_pct, bit noise);
    request_t    r;
    int unsigned hi;
    int          s;
    int          k;
    int          leaked;
    r.op    = ($urandom_range(0, 99) < post_pct) ? OP_POST : OP_MSG;
    r.qn    = 3'($urandom);
    r.size  = 8'($urandom);
    r.unit  = 8'($urandom);
    r.push  = 1'($urandom);
    r.mtag  = 6'($urandom);
    r.flags = 8'($urandom);
    leaked  = 0;
    for (k = 0; k < TAG_COUNT; k++) if (tag_phase[k] == TS_PENDING) leaked++;
    if (leaked >= LEAK_CAP) r.push = 1'b1;
    if (noise) return r;
    if (r.op == OP_POST) begin
      r.qn = qnum_m;
      hi = qbytes_m >> 1;
      if (hi > 255) hi = 255;
      if (hdr_m <= hi) r.size = 8'($urandom_range(hdr_m, hi));
      if (unit_lim_m != 0) r.unit = 8'($urandom_range(0, unit_lim_m - 1));
      r.push = (leaked < LEAK_CAP && $urandom_range(0, 19) == 0) ? 1'b0 : 1'b1;
    end else begin
      s = $urandom_range(0, TAG_COUNT - 1);
      for (k = 0; k < TAG_COUNT; k++) begin
        if (tag_phase[(s + k) % TAG_COUNT] == TS_USED) begin
          r.mtag = 6'((s + k) % TAG_COUNT);
          break;
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        r.flags = (evt_m & ~mask_m) | (mask_m & 8'($urandom));
      end else if ((r.flags & ~mask_m) == evt_m && mask_m != 8'hFF) begin
        // flip the lowest unmasked bit so it reads as a response
        for (k = 0; k < 8; k++) begin
          if (!mask_m[k]) begin
            r.flags[k] = ~r.flags[k];
            break;
          end
        end
      end
    end
    return r;
  endfunction

  // Drive one request, hold it until accepted, then book its result.
  task automatic offer(request_t r, logic typed, result_t typed_res);
    result_t predicted;
    in_valid      <= 1'b1;
    op            <= r.op;
    queue_number  <= r.qn;
    command_size  <= r.size;
    unit_id       <= r.unit;
    push_ok       <= r.push;
    message_tag   <= r.mtag;
    control_flags <= r.flags;
    do @(posedge clk); while (in_stall);
    predicted = track_request(r);
    results_due.push_back(typed ? typed_res : predicted);
  endtask

  // Valid only drops when a gap follows or the block must go idle.
  task automatic pause(bit calm, bit drop);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0 || drop) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // caller lowers cfg_write after the last write of a batch
  task automatic program_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    mirror_reg(idx, val);
  endtask

  task automatic apply_setup(logic rdy, logic [15:0] qb, logic [2:0] qn, logic [7:0] hdr,
                             logic [7:0] ulim, logic [7:0] evt, logic [7:0] msk);
    wait_idle();
    program_reg(CFG_READY, {15'd0, rdy});
    program_reg(CFG_QUEUE_B, qb);
    program_reg(CFG_QUEUE_NUM, {13'd0, qn});
    program_reg(CFG_HEADER_B, {8'd0, hdr});
    program_reg(CFG_UNIT_LIM, {8'd0, ulim});
    program_reg(CFG_EVENT_CODE, {8'd0, evt});
    program_reg(CFG_FLAG_MASK, {8'd0, msk});
    cfg_write <= 1'b0;
  endtask

  // random registers, mostly leaving room for valid posts and events
  task automatic setup_random();
    logic [7:0]  hdr;
    logic [7:0]  msk;
    logic [15:0] qb;
    hdr = 8'($urandom_range(0, 40));
    msk = 8'($urandom & $urandom & $urandom);
    qb  = $urandom_range(0, 1) ? 16'($urandom_range(2 * hdr, 600))
                               : 16'($urandom_range(2 * hdr, 65535));
    apply_setup(1'b1, qb, 3'($urandom), hdr, 8'($urandom_range(1, 255)),
                8'($urandom) & ~msk, msk);
  endtask

  // squeeze: sender runs back to back while the sink holds off for a long time
  task automatic run_phase(int unsigned items, int unsigned post_pct, bit calm, bit squeeze);
    request_t    r;
    int unsigned n;
    for (n = 0; n < items; n++) begin
      if (squeeze && n == 10) hold_request = 1'b1;
      r = make_request(post_pct, $urandom_range(0, 99) < 15);
      offer(r, 1'b0, '0);
      pause(calm, n + 1 == items);
    end
  endtask

  initial begin : stimulus
    vector_t v;
    logic    drop;
    int      i;
    tracker_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (i = 0; i < N_DIRECTED; i++) begin
      v = DIRECTED[i];
      if (v.wr) begin
        wait_idle();
        program_reg(v.reg_idx, v.reg_val);
        cfg_write <= 1'b0;
      end
      offer(v.req, v.typed, v.res);
      drop = (i + 1 == N_DIRECTED) ? 1'b1 : DIRECTED[i + 1].wr;
      pause(1'b0, drop);
    end

    // post-heavy on defaults: fills the pool until no tag is left
    apply_setup(1'b1, 16'd1024, 3'd0, 8'd4, 8'd16, 8'h00, 8'h00);
    run_phase(90, 90, 1'b0, 1'b0);
    // response-heavy: drains it again
    setup_random();
    run_phase(80, 30, 1'b0, 1'b0);
    // top extremes: only size 255 passes, every unit below 255
    apply_setup(1'b1, 16'hFFFF, 3'd7, 8'd255, 8'd255, 8'hFF, 8'h00);
    run_phase(60, 50, 1'b0, 1'b0);
    // bottom extremes: zero-size queue, all flags masked so every message is an event
    apply_setup(1'b1, 16'd0, 3'd0, 8'd0, 8'd1, 8'h00, 8'hFF);
    run_phase(40, 50, 1'b1, 1'b0);
    // engine not ready
    apply_setup(1'b0, 16'd1024, 3'd3, 8'd4, 8'd16, 8'h50, 8'h0F);
    run_phase(30, 50, 1'b0, 1'b0);
    // back-pressure until the input stalls
    setup_random();
    run_phase(80, 50, 1'b1, 1'b1);
    for (i = 0; i < 4; i++) begin
      setup_random();
      run_phase(90, 50, i[0], 1'b0);
    end

    // drain, then give stray results time to show up
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // result side stall: random gaps, calm stretches, and one long hold on request
  initial begin : result_sink
    int unsigned stall_left;
    bit          sink_calm;
    stall_left = 0;
    sink_calm  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall    <= 1'b0;
        hold_request = 1'b0;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 149) == 0) sink_calm = !sink_calm;
        stall_left = sink_calm ? 0 : pick_gap();
      end
    end
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t due;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: status %0d tag %0d descriptor %0h",
               status, tag, descriptor);
        mismatches++;
      end else begin
        due = results_due.pop_front();
        if (status !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, status);
          mismatches++;
        end
        if (tag !== due.tag) begin
          $error("tag: expected %0d, got %0d", due.tag, tag);
          mismatches++;
        end
        if (descriptor !== due.desc) begin
          $error("descriptor: expected %0h, got %0h", due.desc, descriptor);
          mismatches++;
        end
      end
    end
  end

  // hang guard, far above the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
design/ctt_pkg.sv
design/ctt_tag_table.sv
design/command_sequence_tag_tracker_top.sv
tb/sv/tb_top.sv
